FILE: rtl/core/mmcs_pkg.sv
// Shared types and constants for the min/max contrast stretch unit.
`default_nettype none

package mmcs_pkg;

    localparam int PIXEL_BITS_DEF = 8;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_OUT_MIN = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OUT_MAX = 2'd1;

    typedef enum logic
    {
        OP_MEASURE = 1'b0,
        OP_MAP     = 1'b1
    } op_e_t;

    typedef enum logic [1:0]
    {
        ST_MAPPED  = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_FLAT    = 2'd2,
        ST_BADCFG  = 2'd3
    } status_t;

    typedef enum logic [1:0]
    {
        S_IDLE   = 2'd0,
        S_MUL    = 2'd1,
        S_DIV    = 2'd2,
        S_RESULT = 2'd3
    } state_t;

    typedef struct packed
    {
        logic load_item;
        logic mul_load;
        logic div_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed
    {
        logic direct;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/min_max_contrast_stretch_unit.sv
// Top level of the min/max contrast stretch unit.
//
//  channel   direction  handshake             payload
//  in        in         in_valid/in_ready     op, pixel, first
//  out       out        out_valid/out_ready   mapped, status
//  cfg       in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
// Measure beats are taken back to back. A map beat that needs scaling holds
// the unit through the multiply state and the restoring divider, which gives
// one quotient bit per cycle. A passthrough map beat skips the divider.
// The output register lets the next beat in while a result waits; a stalled
// output holds the unit only when a second result is ready to load.
// Reset is asynchronous, active low; no clearing pass is needed.
`default_nettype none

module min_max_contrast_stretch_unit
#(
    parameter int PIXEL_BITS = mmcs_pkg::PIXEL_BITS_DEF
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic                                 op,
    input  wire logic [PIXEL_BITS-1:0]                pixel,
    input  wire logic                                 first,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [PIXEL_BITS-1:0]                     mapped,
    output logic [1:0]                                status,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [mmcs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [PIXEL_BITS-1:0]                cfg_data
);

    mmcs_pkg::ctrl_cmd_t cmd;
    mmcs_pkg::dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    mmcs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mmcs_datapath
    #(
        .PIXEL_BITS (PIXEL_BITS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op        (op),
        .pixel     (pixel),
        .first     (first),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .mapped    (mapped),
        .status    (status),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

FILE: rtl/core/mmcs_ctrl.sv
// Controller state machine: sequences accept, multiply, divide and result load.
`default_nettype none

module mmcs_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 op,
    output logic                      in_ready,
    input  wire mmcs_pkg::dp_stat_t   stat,
    output mmcs_pkg::ctrl_cmd_t       cmd
);

    mmcs_pkg::state_t state_reg;
    mmcs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mmcs_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            mmcs_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (op == mmcs_pkg::OP_MAP)
                    begin
                        state_next = mmcs_pkg::S_MUL;
                    end
                end
            end
            mmcs_pkg::S_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = stat.direct ? mmcs_pkg::S_RESULT : mmcs_pkg::S_DIV;
            end
            mmcs_pkg::S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = mmcs_pkg::S_RESULT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            mmcs_pkg::S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = mmcs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mmcs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/mmcs_datapath.sv
// Datapath: config and tracking registers, multiplier, restoring divider, output register.
`default_nettype none

module mmcs_datapath
#(
    parameter int PIXEL_BITS = mmcs_pkg::PIXEL_BITS_DEF
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    input  wire logic [mmcs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [PIXEL_BITS-1:0]                cfg_data,
    input  wire logic                                 op,
    input  wire logic [PIXEL_BITS-1:0]                pixel,
    input  wire logic                                 first,
    input  wire logic                                 out_ready,
    output logic                                      out_valid,
    output logic [PIXEL_BITS-1:0]                     mapped,
    output logic [1:0]                                status,
    input  wire mmcs_pkg::ctrl_cmd_t                  cmd,
    output mmcs_pkg::dp_stat_t                        stat
);

    localparam int PRODW = 2 * PIXEL_BITS;
    localparam int CNTW  = $clog2(PIXEL_BITS + 1);
    localparam logic [PIXEL_BITS-1:0] OUT_MAX_RST =
        (PIXEL_BITS >= 8) ? PIXEL_BITS'(255) : {PIXEL_BITS{1'b1}};

    logic [PIXEL_BITS-1:0] out_min_reg;
    logic [PIXEL_BITS-1:0] out_max_reg;
    logic [PIXEL_BITS-1:0] lo_reg;
    logic [PIXEL_BITS-1:0] hi_reg;
    logic [PIXEL_BITS-1:0] pix_reg;
    logic [PIXEL_BITS-1:0] div_reg;
    logic [PIXEL_BITS-1:0] rem_reg;
    logic [PIXEL_BITS-1:0] rem_next;
    logic [PIXEL_BITS-1:0] quo_reg;
    logic [PIXEL_BITS-1:0] quo_next;
    logic [CNTW-1:0]       cnt_reg;
    mmcs_pkg::status_t     cls_reg;
    mmcs_pkg::status_t     cls;
    logic                  out_valid_reg;
    logic [PIXEL_BITS-1:0] mapped_reg;
    logic [PIXEL_BITS-1:0] mapped_next;
    mmcs_pkg::status_t     status_reg;

    logic [PIXEL_BITS-1:0] span_out;
    logic [PIXEL_BITS-1:0] offset;
    logic [PRODW-1:0]      prod;
    logic [PIXEL_BITS:0]   shifted;
    logic [PIXEL_BITS:0]   divisor_ext;
    logic                  ge;

    // classification of the held pixel, in priority order
    always_comb
    begin
        if (out_min_reg > out_max_reg)
        begin
            cls = mmcs_pkg::ST_BADCFG;
        end
        else if (pix_reg < lo_reg || pix_reg > hi_reg)
        begin
            cls = mmcs_pkg::ST_OUTSIDE;
        end
        else if (lo_reg == hi_reg)
        begin
            cls = mmcs_pkg::ST_FLAT;
        end
        else
        begin
            cls = mmcs_pkg::ST_MAPPED;
        end
    end

    assign span_out = out_max_reg - out_min_reg;
    assign offset   = pix_reg - lo_reg;
    assign prod     = PRODW'(span_out) * PRODW'(offset);

    // one restoring step per cycle; quotient fits since high half < divisor
    assign shifted     = {rem_reg, quo_reg[PIXEL_BITS-1]};
    assign divisor_ext = {1'b0, div_reg};
    assign ge          = (shifted >= divisor_ext);
    assign rem_next    = ge ? PIXEL_BITS'(shifted - divisor_ext) : shifted[PIXEL_BITS-1:0];
    assign quo_next    = (quo_reg << 1) | PIXEL_BITS'(ge);

    always_comb
    begin
        case (cls_reg)
            mmcs_pkg::ST_MAPPED: mapped_next = out_min_reg + quo_reg;
            mmcs_pkg::ST_FLAT:   mapped_next = out_min_reg;
            default:             mapped_next = pix_reg;
        endcase
    end

    assign stat.direct   = (cls != mmcs_pkg::ST_MAPPED);
    assign stat.div_done = (cnt_reg == CNTW'(PIXEL_BITS));
    assign stat.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_min_reg   <= '0;
            out_max_reg   <= OUT_MAX_RST;
            lo_reg        <= '1;
            hi_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    mmcs_pkg::CFG_OUT_MIN: out_min_reg <= cfg_data;
                    mmcs_pkg::CFG_OUT_MAX: out_max_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.load_item && op == mmcs_pkg::OP_MEASURE)
            begin
                if (first)
                begin
                    lo_reg <= pixel;
                    hi_reg <= pixel;
                end
                else
                begin
                    if (pixel < lo_reg)
                    begin
                        lo_reg <= pixel;
                    end
                    if (pixel > hi_reg)
                    begin
                        hi_reg <= pixel;
                    end
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            pix_reg <= pixel;
        end
        if (cmd.mul_load)
        begin
            {rem_reg, quo_reg} <= prod;
            div_reg            <= hi_reg - lo_reg;
            cls_reg            <= cls;
            cnt_reg            <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg + CNTW'(1);
        end
        if (cmd.out_load)
        begin
            mapped_reg <= mapped_next;
            status_reg <= cls_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign mapped    = mapped_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

FILE: rtl/core/mmcs_checker.sv
// Port-level assertions for the min/max contrast stretch unit, with bind.
`default_nettype none

module mmcs_checker
#(
    parameter int PIXEL_BITS = mmcs_pkg::PIXEL_BITS_DEF
)
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic                  op,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [PIXEL_BITS-1:0] mapped,
    input wire logic [1:0]            status
);

    // a map beat always keeps the unit busy for at least the next cycle
    a_map_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op == mmcs_pkg::OP_MAP |=> !in_ready)
        else $error("unit ready right after a map beat");

    // after a measure beat the unit is ready again in the next cycle
    a_measure_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op == mmcs_pkg::OP_MEASURE |=> in_ready)
        else $error("unit not ready after a measure beat");

    // results only come out of the busy phase of a map beat
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without a map beat in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mapped) && $stable(status))
        else $error("stalled result changed or dropped");

endmodule

bind min_max_contrast_stretch_unit mmcs_checker
#(
    .PIXEL_BITS (PIXEL_BITS)
)
u_mmcs_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .mapped    (mapped),
    .status    (status)
);

`default_nettype wire
